>>> hdl/dns_query_tld_referral_defines.svh
// ----------------------------------------------------------------------------
// DNS query TLD referral: assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef DNS_QUERY_TLD_REFERRAL_DEFINES_SVH
`define DNS_QUERY_TLD_REFERRAL_DEFINES_SVH

// Condition in the same cycle implies the expression in the same cycle.
`define DQTR_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("dqtr: same-cycle check failed");

// Condition in this cycle implies the expression in the next cycle.
`define DQTR_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("dqtr: next-cycle check failed");

`endif

>>> hdl/dqtr_pkg.sv
// ----------------------------------------------------------------------------
// dqtr_pkg
// Types and constants shared by the DNS query TLD referral modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dqtr_pkg;

   // Top-level domain class found in the last label of the question name.
   typedef enum logic [1:0] {
      TLD_NONE,
      TLD_CN_US,
      TLD_COM_ORG,
      TLD_ARPA
   } tld_code_type;

   // One parsed question, handed from the parser to the responder.
   typedef struct packed {
      logic [15:0]  query_id;
      logic [15:0]  question_count;
      logic [15:0]  query_type;
      logic [15:0]  query_class;
      tld_code_type tld;
   } question_type;

   // Response flag words.
   localparam logic [15:0] FLAGS_FOUND      = 16'h8000;
   localparam logic [15:0] FLAGS_NAME_ERROR = 16'h8003;

   // Configuration register indexes and reset values.
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CN_US   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COM_ORG = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ARPA    = 2'd2;

   localparam logic [31:0] RESET_CN_US   = 32'h7F00_0004;
   localparam logic [31:0] RESET_COM_ORG = 32'h7F00_0005;
   localparam logic [31:0] RESET_ARPA    = 32'h7F00_0008;

endpackage

`default_nettype wire

>>> hdl/dqtr_front.sv
// ----------------------------------------------------------------------------
// dqtr_front
// Byte-serial question parser: header, labels, type and class. On the last
// class byte it pushes one classified question into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dqtr_front
   import dqtr_pkg::*;
#(
   parameter int unsigned SUFFIX_KEEP = 4
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         accept,
   input  wire logic [7:0]   message_byte,
   input  wire logic         start_of_message,
   output logic              q_push,
   output question_type      q_data
);

   localparam int unsigned LEN_W = $clog2(SUFFIX_KEEP + 2);

   // Header byte positions.
   localparam logic [3:0] HDR_ID_HI   = 4'd0;
   localparam logic [3:0] HDR_ID_LO   = 4'd1;
   localparam logic [3:0] HDR_QD_HI   = 4'd4;
   localparam logic [3:0] HDR_QD_LO   = 4'd5;
   localparam logic [3:0] HDR_LAST    = 4'd11;

   // Tail byte positions.
   localparam logic [3:0] TAIL_TYPE_HI  = 4'd0;
   localparam logic [3:0] TAIL_TYPE_LO  = 4'd1;
   localparam logic [3:0] TAIL_CLASS_HI = 4'd2;

   // Characters of the known top-level domains.
   localparam logic [7:0] CH_A = 8'h61;
   localparam logic [7:0] CH_C = 8'h63;
   localparam logic [7:0] CH_G = 8'h67;
   localparam logic [7:0] CH_M = 8'h6D;
   localparam logic [7:0] CH_N = 8'h6E;
   localparam logic [7:0] CH_O = 8'h6F;
   localparam logic [7:0] CH_P = 8'h70;
   localparam logic [7:0] CH_R = 8'h72;
   localparam logic [7:0] CH_S = 8'h73;
   localparam logic [7:0] CH_U = 8'h75;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_NAME,
      PH_TAIL,
      PH_IDLE
   } phase_type;

   phase_type         phase_ff, phase_in, phase_cur;
   logic [3:0]        count_ff, count_in, count_cur;
   logic [7:0]        remain_ff, remain_in, remain_cur;
   logic [LEN_W-1:0]  length_ff, length_in, length_cur;
   logic [7:0]        chars_ff [SUFFIX_KEEP];
   logic [7:0]        chars_in [SUFFIX_KEEP];
   logic [15:0]       id_ff, id_in;
   logic [15:0]       qdcount_ff, qdcount_in;
   logic [15:0]       type_ff, type_in;
   logic [7:0]        class_hi_ff, class_hi_in;
   logic              push;
   tld_code_type      tld;

   // Classify the last label as it stands when the class bytes arrive.
   always_comb begin
      tld = TLD_NONE;
      if (length_ff == LEN_W'(2)) begin
         if ((chars_ff[0] == CH_C && chars_ff[1] == CH_N) ||
             (chars_ff[0] == CH_U && chars_ff[1] == CH_S)) begin
            tld = TLD_CN_US;
         end
      end else if (length_ff == LEN_W'(3)) begin
         if ((chars_ff[0] == CH_C && chars_ff[1] == CH_O && chars_ff[2] == CH_M) ||
             (chars_ff[0] == CH_O && chars_ff[1] == CH_R && chars_ff[2] == CH_G)) begin
            tld = TLD_COM_ORG;
         end
      end else if (length_ff == LEN_W'(4)) begin
         if (chars_ff[0] == CH_A && chars_ff[1] == CH_R &&
             chars_ff[2] == CH_P && chars_ff[3] == CH_A) begin
            tld = TLD_ARPA;
         end
      end
   end

   // A start marker restarts the parse before the byte is taken.
   always_comb begin
      phase_cur  = start_of_message ? PH_HEADER : phase_ff;
      count_cur  = start_of_message ? 4'd0 : count_ff;
      remain_cur = start_of_message ? 8'd0 : remain_ff;
      length_cur = start_of_message ? LEN_W'(0) : length_ff;
   end

   // Next-state logic of the parser.
   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      remain_in   = remain_ff;
      length_in   = length_ff;
      id_in       = id_ff;
      qdcount_in  = qdcount_ff;
      type_in     = type_ff;
      class_hi_in = class_hi_ff;
      push        = 1'b0;
      for (int k = 0; k < SUFFIX_KEEP; k++) begin
         chars_in[k] = chars_ff[k];
      end

      if (accept) begin
         phase_in  = phase_cur;
         count_in  = count_cur;
         remain_in = remain_cur;
         length_in = length_cur;
         unique case (phase_cur)
            PH_HEADER: begin
               case (count_cur)
                  HDR_ID_HI: id_in[15:8]      = message_byte;
                  HDR_ID_LO: id_in[7:0]       = message_byte;
                  HDR_QD_HI: qdcount_in[15:8] = message_byte;
                  HDR_QD_LO: qdcount_in[7:0]  = message_byte;
                  default: ;
               endcase
               if (count_cur == HDR_LAST) begin
                  phase_in  = PH_NAME;
                  count_in  = 4'd0;
                  remain_in = 8'd0;
                  length_in = LEN_W'(0);
               end else begin
                  count_in = count_cur + 4'd1;
               end
            end
            PH_NAME: begin
               if (remain_cur == 8'd0) begin
                  if (message_byte == 8'd0) begin
                     phase_in = PH_TAIL;
                     count_in = 4'd0;
                  end else begin
                     remain_in = message_byte;
                     length_in = LEN_W'(0);
                  end
               end else begin
                  // Keep the first bytes of the label; longer labels saturate.
                  if (length_cur < LEN_W'(SUFFIX_KEEP)) begin
                     for (int k = 0; k < SUFFIX_KEEP; k++) begin
                        if (length_cur == LEN_W'(k)) begin
                           chars_in[k] = message_byte;
                        end
                     end
                     length_in = length_cur + LEN_W'(1);
                  end else begin
                     length_in = LEN_W'(SUFFIX_KEEP + 1);
                  end
                  remain_in = remain_cur - 8'd1;
               end
            end
            PH_TAIL: begin
               case (count_cur)
                  TAIL_TYPE_HI: begin
                     type_in[15:8] = message_byte;
                     count_in      = count_cur + 4'd1;
                  end
                  TAIL_TYPE_LO: begin
                     type_in[7:0] = message_byte;
                     count_in     = count_cur + 4'd1;
                  end
                  TAIL_CLASS_HI: begin
                     class_hi_in = message_byte;
                     count_in    = count_cur + 4'd1;
                  end
                  default: begin
                     // Final class byte: hand the question on.
                     push     = 1'b1;
                     phase_in = PH_IDLE;
                     count_in = 4'd0;
                  end
               endcase
            end
            PH_IDLE: ;
            default: ;
         endcase
      end
   end

   // State and held header fields.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         count_ff  <= 4'd0;
         remain_ff <= 8'd0;
         length_ff <= LEN_W'(0);
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         remain_ff <= remain_in;
         length_ff <= length_in;
      end
      id_ff       <= id_in;
      qdcount_ff  <= qdcount_in;
      type_ff     <= type_in;
      class_hi_ff <= class_hi_in;
      for (int k = 0; k < SUFFIX_KEEP; k++) begin
         chars_ff[k] <= chars_in[k];
      end
   end

   assign q_push                = push;
   assign q_data.query_id       = id_ff;
   assign q_data.question_count = qdcount_ff;
   assign q_data.query_type     = type_ff;
   assign q_data.query_class    = {class_hi_ff, message_byte};
   assign q_data.tld            = tld;

endmodule

`default_nettype wire

>>> hdl/dqtr_fifo.sv
// ----------------------------------------------------------------------------
// dqtr_fifo
// Short register queue between the parser and the responder.
// ----------------------------------------------------------------------------
`default_nettype none

module dqtr_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == CNT_W'(0));
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slots_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= PTR_W'(0);
         rd_ptr_ff <= PTR_W'(0);
         count_ff  <= CNT_W'(0);
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> hdl/dqtr_back.sv
// ----------------------------------------------------------------------------
// dqtr_back
// Responder: holds the referral registers, resolves a queued question into
// a response and keeps it in the output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dqtr_back
   import dqtr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]            csr_write_data,
   input  wire question_type           q_data,
   input  wire logic                   q_empty,
   output logic                        q_pop,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output logic [15:0]                 rsp_query_id,
   output logic [15:0]                 rsp_question_count,
   output logic [15:0]                 rsp_query_type,
   output logic [15:0]                 rsp_query_class,
   output logic                        rsp_referral_found,
   output logic [31:0]                 rsp_next_server_addr,
   output logic [15:0]                 rsp_response_flags,
   output logic                        rsp_authority_count
);

   logic [31:0]  cn_us_ff, cn_us_in;
   logic [31:0]  com_org_ff, com_org_in;
   logic [31:0]  arpa_ff, arpa_in;
   logic         valid_ff, valid_in;
   logic         load;
   logic         found;
   logic [31:0]  addr;
   question_type q_ff;
   logic         found_ff;
   logic [31:0]  addr_ff;

   assign csr_ready = 1'b1;

   // Register writes; unknown indexes are dropped.
   always_comb begin
      cn_us_in   = cn_us_ff;
      com_org_in = com_org_ff;
      arpa_in    = arpa_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CN_US:   cn_us_in   = csr_write_data;
            CSR_COM_ORG: com_org_in = csr_write_data;
            CSR_ARPA:    arpa_in    = csr_write_data;
            default: ;
         endcase
      end
   end

   // Referral lookup for the question at the head of the queue.
   always_comb begin
      unique case (q_data.tld)
         TLD_CN_US: begin
            found = 1'b1;
            addr  = cn_us_ff;
         end
         TLD_COM_ORG: begin
            found = 1'b1;
            addr  = com_org_ff;
         end
         TLD_ARPA: begin
            found = 1'b1;
            addr  = arpa_ff;
         end
         default: begin
            found = 1'b0;
            addr  = 32'd0;
         end
      endcase
   end

   // The output register refills from a non-empty queue whenever it is free or being emptied.
   assign load     = !q_empty && (!valid_ff || rsp_pop);
   assign q_pop    = load;
   assign valid_in = load ? 1'b1 : (rsp_pop ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cn_us_ff   <= RESET_CN_US;
         com_org_ff <= RESET_COM_ORG;
         arpa_ff    <= RESET_ARPA;
         valid_ff   <= 1'b0;
      end else begin
         cn_us_ff   <= cn_us_in;
         com_org_ff <= com_org_in;
         arpa_ff    <= arpa_in;
         valid_ff   <= valid_in;
      end
      if (load) begin
         q_ff     <= q_data;
         found_ff <= found;
         addr_ff  <= addr;
      end
   end

   assign rsp_empty            = !valid_ff;
   assign rsp_query_id         = q_ff.query_id;
   assign rsp_question_count   = q_ff.question_count;
   assign rsp_query_type       = q_ff.query_type;
   assign rsp_query_class      = q_ff.query_class;
   assign rsp_referral_found   = found_ff;
   assign rsp_next_server_addr = addr_ff;
   assign rsp_response_flags   = found_ff ? FLAGS_FOUND : FLAGS_NAME_ERROR;
   assign rsp_authority_count  = found_ff;

endmodule

`default_nettype wire

>>> hdl/dns_query_tld_referral.sv
// ----------------------------------------------------------------------------
// dns_query_tld_referral
// DNS question parser with top-level domain referral lookup.
// ----------------------------------------------------------------------------
// Usage: push the query message one byte per beat on the req_ channel, from
// the first header byte on, with req_start_of_message high on that byte. A
// start marker in the middle of a message restarts the parse.
// Throughput: one byte per cycle, sustained; the byte parser takes a beat in
// every cycle that req_full is low.
// Path: the question from the beat that carries the last class byte is
// registered into the question queue, then into the output register, which
// takes it once it is free or being popped and drives the rsp_ ports. Bytes
// after the class are dropped until the next start marker.
// Stalls: the response stays on the rsp_ ports until popped. Behind it the
// question queue holds QUEUE_DEPTH questions; req_full rises only when that
// queue is full, so the parser keeps taking bytes while the receiver waits.
// Configuration: the csr_ channel writes the three referral addresses and is
// always ready. Reset clears the parser, the queue and the output register
// and restores the default addresses (127.0.0.4, 127.0.0.5, 127.0.0.8).
// ----------------------------------------------------------------------------
`default_nettype none

`include "dns_query_tld_referral_defines.svh"

module dns_query_tld_referral
   import dqtr_pkg::*;
#(
   parameter int unsigned SUFFIX_KEEP = 4,
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_push,
   output logic                        req_full,
   input  wire logic [7:0]             req_message_byte,
   input  wire logic                   req_start_of_message,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output logic [15:0]                 rsp_query_id,
   output logic [15:0]                 rsp_question_count,
   output logic [15:0]                 rsp_query_type,
   output logic [15:0]                 rsp_query_class,
   output logic                        rsp_referral_found,
   output logic [31:0]                 rsp_next_server_addr,
   output logic [15:0]                 rsp_response_flags,
   output logic                        rsp_authority_count,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]            csr_write_data
);

   logic         accept;
   logic         q_push;
   logic         q_full;
   logic         q_empty;
   logic         q_pop;
   question_type q_in;
   question_type q_out;

   assign accept   = req_push && !q_full;
   assign req_full = q_full;

   // Byte parser.
   dqtr_front #(
      .SUFFIX_KEEP (SUFFIX_KEEP)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .message_byte     (req_message_byte),
      .start_of_message (req_start_of_message),
      .q_push           (q_push),
      .q_data           (q_in)
   );

   // Question queue between parser and responder.
   dqtr_fifo #(
      .WIDTH ($bits(question_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   // Referral lookup and output register.
   dqtr_back u_back (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .q_data               (q_out),
      .q_empty              (q_empty),
      .q_pop                (q_pop),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_query_id         (rsp_query_id),
      .rsp_question_count   (rsp_question_count),
      .rsp_query_type       (rsp_query_type),
      .rsp_query_class      (rsp_query_class),
      .rsp_referral_found   (rsp_referral_found),
      .rsp_next_server_addr (rsp_next_server_addr),
      .rsp_response_flags   (rsp_response_flags),
      .rsp_authority_count  (rsp_authority_count)
   );

   // The parser never pushes into a full queue.
   `DQTR_ASSERT_SAME(a_no_push_when_full, clock, reset, q_push, !q_full)

   // A waiting response blocks the queue from draining.
   `DQTR_ASSERT_SAME(a_hold_blocks_queue, clock, reset, !rsp_empty && !rsp_pop, !q_pop)

   // With nothing queued and nothing shown, no response can appear.
   `DQTR_ASSERT_NEXT(a_no_invented_rsp, clock, reset, rsp_empty && q_empty, rsp_empty)

   // The flag word agrees with the referral decision.
   `DQTR_ASSERT_SAME(a_flags_match, clock, reset, !rsp_empty,
      rsp_referral_found == (rsp_response_flags == FLAGS_FOUND))

endmodule

`default_nettype wire
